// File: hdl/clap_direction_sector_finder_macros.svh
// Assertion macros shared by the clap direction sector finder checkers.
`ifndef CLAP_DIRECTION_SECTOR_FINDER_MACROS_SVH
`define CLAP_DIRECTION_SECTOR_FINDER_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define CDSF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("cdsf assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define CDSF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cdsf assertion failed");

// Consequent holds in the cycle after the antecedent.
`define CDSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cdsf assertion failed");

`endif

// File: hdl/cdsf_pkg.sv
// Types and constants shared by the clap direction sector finder modules.
`timescale 1ns / 1ps

package cdsf_pkg;

    // Input transaction: tick or microphone edge
    typedef struct packed {
        logic       operation;
        logic [1:0] mic_index;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [3:0]  sector;
        logic [1:0]  first_mic;
        logic [1:0]  second_mic;
        logic [1:0]  last_mic;
        logic [15:0] delay_us;
        logic        in_range;
    } out_item_t;

    // Configuration register file
    typedef struct packed {
        logic [7:0]  spacing_0_2;
        logic [7:0]  spacing_1_0;
        logic [7:0]  spacing_2_1;
        logic [7:0]  tick_us;
        logic [15:0] sound_speed;
    } cfg_regs_t;

    // Arrival order of one finished capture
    typedef struct packed {
        logic [1:0] first_mic;
        logic [1:0] second_mic;
        logic [1:0] last_mic;
    } mic_order_t;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Microphone indexes
    localparam logic [1:0] MIC_0    = 2'd0;
    localparam logic [1:0] MIC_1    = 2'd1;
    localparam logic [1:0] MIC_2    = 2'd2;
    localparam logic [1:0] MIC_NONE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_0_2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_1_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_2_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_SPACING_0_2 = 8'd14;
    localparam logic [7:0]  RST_SPACING_1_0 = 8'd16;
    localparam logic [7:0]  RST_SPACING_2_1 = 8'd16;
    localparam logic [7:0]  RST_TICK_US     = 8'd8;
    localparam logic [15:0] RST_SOUND_SPEED = 16'd2230;

    // Q1.16 thresholds: unity (range limit), sin 15, sin 45, sin 75
    localparam int unsigned THR_W = 17;
    localparam logic [THR_W-1:0] THRESH_Q16 [4] = '{
        17'd65536, 17'd16962, 17'd46341, 17'd63302
    };

    // Sector by {last_mic, first_is, bucket}
    localparam logic [3:0] SECTOR_NONE = 4'd0;
    localparam logic [3:0] SECTOR_MAX  = 4'd12;
    localparam logic [3:0] SECTOR_LUT [24] = '{
        4'd1, 4'd12, 4'd11, 4'd10,  4'd1, 4'd2,  4'd3,  4'd4,
        4'd9, 4'd8,  4'd7,  4'd6,   4'd9, 4'd10, 4'd11, 4'd12,
        4'd5, 4'd6,  4'd7,  4'd8,   4'd5, 4'd4,  4'd3,  4'd2
    };

endpackage

// File: hdl/cdsf_capture.sv
// Tick counter and arrival capture for the three microphones.
`timescale 1ns / 1ps

module cdsf_capture import cdsf_pkg::*; #(
    parameter int unsigned TIMER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  in_item_t              s_item,
    output logic                  done,
    output mic_order_t            order,
    output logic [TIMER_BITS-1:0] gap
);

    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [1:0]            stage_reg, stage_next;
    logic [2:0]            mask_reg, mask_next;
    logic [TIMER_BITS-1:0] arrival_time_reg [3];
    logic [1:0]            arrival_order_reg [3];

    logic [2:0]            mic_bit;
    logic                  fresh;
    logic [TIMER_BITS-1:0] stamp;
    logic [TIMER_BITS-1:0] time_a, time_b;

    // One-hot of the edge's microphone; index 3 maps to nothing
    always_comb begin
        case (s_item.mic_index)
            MIC_0:   mic_bit = 3'b001;
            MIC_1:   mic_bit = 3'b010;
            MIC_2:   mic_bit = 3'b100;
            default: mic_bit = 3'b000;
        endcase
    end

    assign fresh = accept && (s_item.operation == OP_EDGE) && (mic_bit != 3'b000)
                   && ((mask_reg & mic_bit) == 3'b000);
    assign stamp = (stage_reg == 2'd0) ? '0 : tick_reg;
    assign done  = fresh && (stage_reg == 2'd2);

    // Counter, stage and heard mask
    always_comb begin
        tick_next  = tick_reg;
        stage_next = stage_reg;
        mask_next  = mask_reg;
        if (accept && (s_item.operation == OP_TICK)) begin
            tick_next = tick_reg + 1'b1;
        end else if (fresh) begin
            tick_next = stamp;
            if (stage_reg == 2'd2) begin
                stage_next = 2'd0;
                mask_next  = 3'b000;
            end else begin
                stage_next = stage_reg + 2'd1;
                mask_next  = mask_reg | mic_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            stage_reg <= 2'd0;
            mask_reg  <= 3'b000;
        end else begin
            tick_reg  <= tick_next;
            stage_reg <= stage_next;
            mask_reg  <= mask_next;
        end
    end

    // Arrival time and order stores
    always_ff @(posedge aclk) begin
        if (fresh) begin
            arrival_time_reg[s_item.mic_index]  <= stamp;
            arrival_order_reg[stage_reg]        <= s_item.mic_index;
        end
    end

    // Reference pair is the two microphones other than the last one
    always_comb begin
        case (s_item.mic_index)
            MIC_0: begin
                time_a = arrival_time_reg[2];
                time_b = arrival_time_reg[1];
            end
            MIC_1: begin
                time_a = arrival_time_reg[0];
                time_b = arrival_time_reg[2];
            end
            default: begin
                time_a = arrival_time_reg[1];
                time_b = arrival_time_reg[0];
            end
        endcase
    end

    assign gap = (time_a >= time_b) ? (time_a - time_b) : (time_b - time_a);

    assign order.first_mic  = arrival_order_reg[0];
    assign order.second_mic = arrival_order_reg[1];
    assign order.last_mic   = s_item.mic_index;

endmodule

// File: hdl/cdsf_mult.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module cdsf_mult #(
    parameter int unsigned AW = 16,
    parameter int unsigned BW = 17
) (
    input  logic            aclk,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    logic [AW+BW-1:0] p_reg;

    // One product per cycle
    always_ff @(posedge aclk) begin
        p_reg <= (AW+BW)'(a) * (AW+BW)'(b);
    end

    assign p = p_reg;

endmodule

// File: hdl/cdsf_solver.sv
// Sequencer that runs delay, distance and threshold products through the
// shared multiplier, then picks the sector and holds the result.
`timescale 1ns / 1ps

module cdsf_solver import cdsf_pkg::*; #(
    parameter int unsigned TIMER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_regs_t             cfg,
    input  logic                  start,
    input  mic_order_t            order,
    input  logic [TIMER_BITS-1:0] gap,
    output logic                  idle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    localparam int unsigned DW = TIMER_BITS + 8;     // delay width
    localparam int unsigned XW = DW + 16;            // distance width
    localparam int unsigned AW = DW;
    localparam int unsigned PW = AW + THR_W;
    localparam int unsigned SW = (DW > 16) ? DW : 16;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MDLY  = 6'b000010,
        ST_MDIST = 6'b000100,
        ST_MTHR  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_OUT   = 6'b100000
    } solver_state_t;

    solver_state_t         state_reg, state_next;
    logic [TIMER_BITS-1:0] gap_reg, gap_next;
    mic_order_t            order_reg, order_next;
    logic                  first_is_reg, first_is_next;
    logic [7:0]            spacing_reg, spacing_next;
    logic [DW-1:0]         delay_reg, delay_next;
    logic [XW-1:0]         dist_reg, dist_next;
    logic [1:0]            thr_idx_reg, thr_idx_next;
    logic [3:0]            ge_reg, ge_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    logic [AW-1:0]         mul_a;
    logic [THR_W-1:0]      mul_b;
    logic [PW-1:0]         mul_p;
    logic                  dist_ge;
    logic                  in_range;
    logic [1:0]            bucket;
    logic [SW-1:0]         delay_ext;
    out_item_t             result;

    cdsf_mult #(
        .AW (AW),
        .BW (THR_W)
    ) u_mult (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // Operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MDLY: begin
                mul_a = AW'(gap_reg);
                mul_b = THR_W'(cfg.tick_us);
            end
            ST_MDIST: begin
                mul_a = mul_p[AW-1:0];
                mul_b = THR_W'(cfg.sound_speed);
            end
            ST_MTHR: begin
                mul_a = AW'(spacing_reg);
                mul_b = THRESH_Q16[thr_idx_reg];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Distance against the threshold product now in the multiplier register
    assign dist_ge = ({1'b0, dist_reg} >= mul_p);

    // Result assembly
    assign in_range  = !ge_reg[0];
    assign bucket    = ge_reg[3] ? 2'd3 : (ge_reg[2] ? 2'd2 : (ge_reg[1] ? 2'd1 : 2'd0));
    assign delay_ext = SW'(delay_reg);

    always_comb begin
        result.sector     = in_range ? SECTOR_LUT[{order_reg.last_mic, first_is_reg, bucket}]
                                     : SECTOR_NONE;
        result.first_mic  = order_reg.first_mic;
        result.second_mic = order_reg.second_mic;
        result.last_mic   = order_reg.last_mic;
        result.delay_us   = (delay_ext > SW'(16'hFFFF)) ? 16'hFFFF : delay_ext[15:0];
        result.in_range   = in_range;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        gap_next      = gap_reg;
        order_next    = order_reg;
        first_is_next = first_is_reg;
        spacing_next  = spacing_reg;
        delay_next    = delay_reg;
        dist_next     = dist_reg;
        thr_idx_next  = thr_idx_reg;
        ge_next       = ge_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    gap_next   = gap;
                    order_next = order;
                    case (order.last_mic)
                        MIC_0: begin
                            spacing_next  = cfg.spacing_2_1;
                            first_is_next = (order.first_mic == MIC_1);
                        end
                        MIC_1: begin
                            spacing_next  = cfg.spacing_0_2;
                            first_is_next = (order.first_mic == MIC_2);
                        end
                        default: begin
                            spacing_next  = cfg.spacing_1_0;
                            first_is_next = (order.first_mic == MIC_1);
                        end
                    endcase
                    state_next = ST_MDLY;
                end
            end
            ST_MDLY: begin
                state_next = ST_MDIST;
            end
            ST_MDIST: begin
                delay_next   = mul_p[DW-1:0];
                thr_idx_next = 2'd0;
                state_next   = ST_MTHR;
            end
            ST_MTHR: begin
                if (thr_idx_reg == 2'd0) begin
                    dist_next = mul_p[XW-1:0];
                end else begin
                    ge_next[thr_idx_reg - 2'd1] = dist_ge;
                end
                thr_idx_next = thr_idx_reg + 2'd1;
                if (thr_idx_reg == 2'd3) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ge_next[3] = dist_ge;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg      <= gap_next;
        order_reg    <= order_next;
        first_is_reg <= first_is_next;
        spacing_reg  <= spacing_next;
        delay_reg    <= delay_next;
        dist_reg     <= dist_next;
        thr_idx_reg  <= thr_idx_next;
        ge_reg       <= ge_next;
        m_item_reg   <= m_item_next;
    end

    assign idle    = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: hdl/clap_direction_sector_finder.sv
// Clap direction sector finder: top level with configuration registers.
//
// A tick, a repeated or unknown microphone edge, and the first two distinct
// edges of a capture leave s_ready high, so the next transaction can follow
// at once. The third distinct edge hands the arrival gap to a sequencer that
// runs six products through one shared multiplier (gap times tick_us, delay
// times sound speed, then the spacing times unity and the sines of 15, 45 and
// 75 degrees, each compared with the distance): s_ready then stays low until
// the sequencer is idle, also while a previous result waits in the output
// register. A result stays on m_item until taken, and ticks and edges are
// accepted meanwhile. Configuration writes take effect on the next clock.
`timescale 1ns / 1ps

module clap_direction_sector_finder import cdsf_pkg::*; #(
    parameter int unsigned TIMER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    cfg_regs_t             cfg_reg, cfg_next;
    logic                  accept;
    logic                  idle;
    logic                  done;
    mic_order_t            order;
    logic [TIMER_BITS-1:0] gap;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_SPACING_0_2: cfg_next.spacing_0_2 = cfg_wdata[7:0];
                CFG_SPACING_1_0: cfg_next.spacing_1_0 = cfg_wdata[7:0];
                CFG_SPACING_2_1: cfg_next.spacing_2_1 = cfg_wdata[7:0];
                CFG_TICK_US:     cfg_next.tick_us     = cfg_wdata[7:0];
                CFG_SOUND_SPEED: cfg_next.sound_speed = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spacing_0_2 <= RST_SPACING_0_2;
            cfg_reg.spacing_1_0 <= RST_SPACING_1_0;
            cfg_reg.spacing_2_1 <= RST_SPACING_2_1;
            cfg_reg.tick_us     <= RST_TICK_US;
            cfg_reg.sound_speed <= RST_SOUND_SPEED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input handshake
    assign s_ready = idle;
    assign accept  = s_valid && s_ready;

    cdsf_capture #(
        .TIMER_BITS (TIMER_BITS)
    ) u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .s_item  (s_item),
        .done    (done),
        .order   (order),
        .gap     (gap)
    );

    cdsf_solver #(
        .TIMER_BITS (TIMER_BITS)
    ) u_solver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .start   (done),
        .order   (order),
        .gap     (gap),
        .idle    (idle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// File: hdl/cdsf_checker.sv
// Port-level checks for the clap direction sector finder, bound to the top.
`timescale 1ns / 1ps
`include "clap_direction_sector_finder_macros.svh"

module cdsf_checker import cdsf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A waiting result holds until taken
    `CDSF_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_item))

    // Sector zero exactly when out of range
    `CDSF_ASSERT_IMPLY(a_sector_range, m_valid, (m_item.sector == SECTOR_NONE) == !m_item.in_range)

    // The three arrivals name three different microphones
    `CDSF_ASSERT_IMPLY(a_mics_distinct, m_valid, (m_item.first_mic != m_item.second_mic) && (m_item.first_mic != m_item.last_mic) && (m_item.second_mic != m_item.last_mic))

    // Sector stays on the clock face
    `CDSF_ASSERT_IMPLY(a_sector_max, m_valid, m_item.sector <= SECTOR_MAX)

endmodule

bind clap_direction_sector_finder cdsf_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: tb/sv/tb.sv
// Self-checking testbench for the clap direction sector finder.
`timescale 1ns / 1ps

module tb;
    import cdsf_pkg::*;

    localparam int TIMER_BITS   = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_GAP      = 24;
    localparam int PHASE_QUOTA  = 230;

    // Q0.16 sines of 15, 45 and 75 degrees
    localparam longint unsigned Q16_SIN15 = 16962;
    localparam longint unsigned Q16_SIN45 = 46341;
    localparam longint unsigned Q16_SIN75 = 63302;

    // Clock sector by last microphone, first-microphone side and angle bucket
    localparam int CLOCK_SECTOR [24] = '{
        1, 12, 11, 10,  1, 2, 3, 4,
        9, 8, 7, 6,     9, 10, 11, 12,
        5, 6, 7, 8,     5, 4, 3, 2
    };

    // Pacing per phase: sender idle and receiver stall, percent of cycles
    localparam int SEND_IDLE  [4] = '{0, 59, 0, 31};
    localparam int RECV_STALL [4] = '{0, 0, 59, 31};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;

    clap_direction_sector_finder #(
        .TIMER_BITS(TIMER_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // Shadow registers, as the block should hold them
    logic [7:0]  spacing_02;
    logic [7:0]  spacing_10;
    logic [7:0]  spacing_21;
    logic [7:0]  tick_us;
    logic [15:0] sound_speed;

    // Capture state of the predictor
    logic [TIMER_BITS-1:0] tick_cnt;
    logic [TIMER_BITS-1:0] arrival_at [3];
    logic [1:0]            arrival_rank [3];
    logic [2:0]            heard;
    int                    stage;

    out_item_t awaited_fixes [$];

    int mismatches;
    int items_accepted;
    int fixes_checked;
    int settings_applied;
    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_left;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop if the block hangs
    initial begin
        #8_000_000;
        $display("clap_direction_sector_finder test failed");
        $finish;
    end

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Direction fix for the capture just completed
    function automatic out_item_t predict_fix();
        out_item_t       fix;
        logic [1:0]      first_m;
        logic [1:0]      last_m;
        logic [1:0]      pa;
        logic [1:0]      pb;
        logic [7:0]      spacing;
        int              side;
        int              bucket;
        longint unsigned gap;
        longint unsigned delay;
        longint unsigned travel;
        longint unsigned span;
        first_m = arrival_rank[0];
        last_m  = arrival_rank[2];
        // the two microphones other than the last one form the pair
        case (last_m)
            MIC_0: begin
                pa = MIC_2; pb = MIC_1; spacing = spacing_21;
                side = (first_m == MIC_1) ? 1 : 0;
            end
            MIC_1: begin
                pa = MIC_0; pb = MIC_2; spacing = spacing_02;
                side = (first_m == MIC_2) ? 1 : 0;
            end
            default: begin
                pa = MIC_1; pb = MIC_0; spacing = spacing_10;
                side = (first_m == MIC_1) ? 1 : 0;
            end
        endcase
        if (arrival_at[pa] >= arrival_at[pb])
            gap = longint'(arrival_at[pa]) - longint'(arrival_at[pb]);
        else
            gap = longint'(arrival_at[pb]) - longint'(arrival_at[pa]);
        delay  = gap * longint'(tick_us);
        travel = delay * longint'(sound_speed);
        span   = longint'(spacing);
        fix.first_mic  = first_m;
        fix.second_mic = arrival_rank[1];
        fix.last_mic   = last_m;
        fix.delay_us   = (delay > 65535) ? 16'hFFFF : delay[15:0];
        if (travel < (span << 16)) begin
            bucket = 0;
            if (travel >= span * Q16_SIN15) bucket = 1;
            if (travel >= span * Q16_SIN45) bucket = 2;
            if (travel >= span * Q16_SIN75) bucket = 3;
            fix.sector   = 4'(CLOCK_SECTOR[int'(last_m) * 8 + side * 4 + bucket]);
            fix.in_range = 1'b1;
        end else begin
            fix.sector   = SECTOR_NONE;
            fix.in_range = 1'b0;
        end
        return fix;
    endfunction

    // Track one accepted transaction; queue a fix on the third new microphone
    task automatic advance_capture(input in_item_t it);
        if (it.operation == OP_TICK) begin
            tick_cnt = tick_cnt + 1'b1;
            return;
        end
        if (it.mic_index == MIC_NONE || heard[it.mic_index])
            return;
        if (stage == 0)
            tick_cnt = '0;
        arrival_at[it.mic_index] = tick_cnt;
        arrival_rank[stage]      = it.mic_index;
        heard[it.mic_index]      = 1'b1;
        stage++;
        if (stage == 3) begin
            awaited_fixes.push_back(predict_fix());
            stage = 0;
            heard = '0;
        end
    endtask

    // Input monitor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            advance_capture(s_item);
            items_accepted++;
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_fixes
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_fixes.size() == 0) begin
                report_mismatch("result transaction with nothing awaited");
            end else begin
                want = awaited_fixes.pop_front();
                check_field("sector", 32'(m_item.sector), 32'(want.sector));
                check_field("first_mic", 32'(m_item.first_mic), 32'(want.first_mic));
                check_field("second_mic", 32'(m_item.second_mic), 32'(want.second_mic));
                check_field("last_mic", 32'(m_item.last_mic), 32'(want.last_mic));
                check_field("delay_us", 32'(m_item.delay_us), 32'(want.delay_us));
                check_field("in_range", 32'(m_item.in_range), 32'(want.in_range));
            end
            fixes_checked++;
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
                holdoff_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one transaction; returns on the falling edge after acceptance
    task automatic send_item(input logic op, input logic [1:0] mic);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{operation: op, mic_index: mic};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int count);
        logic [1:0] junk;
        for (int i = 0; i < count; i++) begin
            junk = 2'($urandom_range(3));
            send_item(OP_TICK, junk);
        end
    endtask

    // Stop offering and wait for every awaited fix plus the block's latency
    task automatic quiesce();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (awaited_fixes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write all five registers; 8-bit ones get junk in the upper byte
    task automatic apply_settings(input logic [7:0] sp02, input logic [7:0] sp10,
                                  input logic [7:0] sp21, input logic [7:0] tick,
                                  input logic [15:0] speed);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        logic [7:0]            junk;
        regs = '{CFG_SPACING_0_2, CFG_SPACING_1_0, CFG_SPACING_2_1,
                 CFG_TICK_US, CFG_SOUND_SPEED};
        junk = 8'($urandom_range(255));
        vals = '{{junk, sp02}, {~junk, sp10}, {junk, sp21}, {~junk, tick}, speed};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_we      <= 1'b0;
        spacing_02  = sp02;
        spacing_10  = sp10;
        spacing_21  = sp21;
        tick_us     = tick;
        sound_speed = speed;
        settings_applied++;
    endtask

    // Tick gap between the first two edges: mostly short, sometimes past a wrap
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return $urandom_range(6);
        if (roll < 85) return $urandom_range(40);
        if (roll < 97) return $urandom_range(100);
        return $urandom_range(300, 200);
    endfunction

    // Mostly complete captures, plus lone ticks and broken sequences
    task automatic random_captures(input int quota);
        int         done;
        int         roll;
        int         n;
        int         mic_a;
        int         mic_b;
        logic [1:0] order [3];
        logic [1:0] stray;
        done = 0;
        while (done < quota) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                mic_a = $urandom_range(2);
                mic_b = (mic_a + 1 + $urandom_range(1)) % 3;
                order[0] = 2'(mic_a);
                order[1] = 2'(mic_b);
                order[2] = 2'(3 - mic_a - mic_b);
                for (int k = 0; k < 3; k++) begin
                    if (k == 0)      n = $urandom_range(2);
                    else if (k == 1) n = pick_gap();
                    else             n = $urandom_range(3);
                    send_ticks(n);
                    done += n;
                    // occasional repeat or unknown microphone in the middle
                    if ($urandom_range(9) == 0) begin
                        if (k == 0 || $urandom_range(1) == 0) stray = MIC_NONE;
                        else stray = order[$urandom_range(k - 1)];
                        send_item(OP_EDGE, stray);
                    end
                    send_item(OP_EDGE, order[k]);
                    done++;
                end
            end else if (roll < 90) begin
                n = pick_gap();
                send_ticks(n);
                done += n;
            end else begin
                stray = 2'($urandom_range(3));
                send_item(OP_EDGE, stray);
            end
        end
    endtask

    // Register reset values feed the arithmetic before any write
    task automatic test_reset_defaults();
        send_item(OP_EDGE, MIC_2);
        send_ticks(3);
        send_item(OP_EDGE, MIC_0);
        send_item(OP_EDGE, MIC_1);
        quiesce();
    endtask

    // Buckets 0, 1 and 3, unknown and repeated microphones, each operation
    task automatic test_directed();
        // about 20 cm per tick against 100 cm spacing
        apply_settings(8'd100, 8'd100, 8'd100, 8'd20, 16'hFFFF);
        send_item(OP_EDGE, MIC_0);
        send_item(OP_EDGE, MIC_NONE);
        send_item(OP_EDGE, MIC_0);
        send_item(OP_EDGE, MIC_1);
        send_item(OP_EDGE, MIC_2);
        send_item(OP_EDGE, MIC_1);
        send_ticks(2);
        send_item(OP_EDGE, MIC_0);
        send_item(OP_TICK, MIC_NONE);
        send_item(OP_EDGE, MIC_2);
        send_item(OP_EDGE, MIC_2);
        send_ticks(5);
        send_item(OP_EDGE, MIC_0);
        send_item(OP_EDGE, MIC_1);
        send_item(OP_EDGE, MIC_1);
        send_item(OP_EDGE, MIC_2);
        send_item(OP_EDGE, MIC_2);
        send_item(OP_EDGE, MIC_0);
        quiesce();
    endtask

    // One random phase under a given setting and pacing mode
    task automatic test_random_phase(input int phase);
        send_idle_pct  = SEND_IDLE[phase % 4];
        recv_stall_pct = RECV_STALL[phase % 4];
        case (phase)
            0: apply_settings(RST_SPACING_0_2, RST_SPACING_1_0, RST_SPACING_2_1,
                              RST_TICK_US, RST_SOUND_SPEED);
            1: apply_settings(8'd60, 8'd50, 8'd40, 8'd255, 16'd2230);
            2: apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
            3: apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
            4: apply_settings(8'd0, 8'd37, 8'd0, 8'd90, 16'd4000);
            5: apply_settings(8'd30, 8'd30, 8'd30, 8'd0, 16'd30000);
            6: apply_settings(8'd45, 8'd200, 8'd9, 8'd120, 16'd0);
            default: apply_settings(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                                    8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                                    16'($urandom_range(65535, 1)));
        endcase
        random_captures(PHASE_QUOTA);
        quiesce();
    endtask

    // Receiver holds off while captures keep arriving, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_settings(8'd60, 8'd50, 8'd40, 8'd255, 16'd2230);
        holdoff_left = 300;
        for (int i = 0; i < 6; i++) begin
            send_item(OP_EDGE, MIC_1);
            send_ticks(i % 4);
            send_item(OP_EDGE, MIC_2);
            send_item(OP_EDGE, MIC_0);
        end
        quiesce();
    endtask

    // Test sequence
    initial begin
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_item           <= '0;
        mismatches       = 0;
        items_accepted   = 0;
        fixes_checked    = 0;
        settings_applied = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        holdoff_left     = 0;
        spacing_02       = RST_SPACING_0_2;
        spacing_10       = RST_SPACING_1_0;
        spacing_21       = RST_SPACING_2_1;
        tick_us          = RST_TICK_US;
        sound_speed      = RST_SOUND_SPEED;
        tick_cnt         = '0;
        heard            = '0;
        stage            = 0;
        for (int i = 0; i < 3; i++) begin
            arrival_at[i]   = '0;
            arrival_rank[i] = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed();
        for (int p = 0; p < 8; p++)
            test_random_phase(p);
        test_backpressure();

        $display("Covered %0d input transactions and %0d direction fixes under %0d settings,",
                 items_accepted, fixes_checked, settings_applied);
        $display("with four pacing modes and one long receiver hold-off; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("clap_direction_sector_finder test passed");
        end else begin
            $display("clap_direction_sector_finder test failed");
        end
        $finish;
    end

endmodule

// File: clap_direction_sector_finder.f
+incdir+hdl
hdl/cdsf_pkg.sv
hdl/cdsf_capture.sv
hdl/cdsf_mult.sv
hdl/cdsf_solver.sv
hdl/clap_direction_sector_finder.sv
hdl/cdsf_checker.sv
tb/sv/tb.sv
